// ----- src/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle span rasterizer package
// Shared widths, request codes, coordinate type and the edge request bundle.
// ----------------------------------------------------------------------------
package tsr_pkg;

    // Width of every vertex coordinate, row and span endpoint.
    localparam int COORD_BITS = 12;

    // Step counter width for the serial multiply and divide phases.
    localparam int CNT_BITS = $clog2(COORD_BITS);

    // Packed stream widths, padded to whole bytes.
    localparam int IN_BITS        = 6 * COORD_BITS + 32;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = 3 * COORD_BITS + 32;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Request kinds carried in tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SPAN = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One edge evaluation: endpoints a and b, and the row to sample.
    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t b_x;
        coord_t b_y;
        coord_t y;
    } edge_req_t;

endpackage

// ----- src/tsr_edge.sv -----
// ----------------------------------------------------------------------------
// Edge interpolator
// Computes a.x + (b.x-a.x)*(y-a.y)/(b.y-a.y) with a bit-serial shift-add
// multiply followed by a bit-serial restoring divide on magnitudes.
// ----------------------------------------------------------------------------
module tsr_edge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  tsr_pkg::edge_req_t req,
    output logic               done,
    output tsr_pkg::coord_t    x_out
);
    import tsr_pkg::*;

    logic                    busy_reg;
    logic                    mul_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [COORD_BITS-1:0]   hi_reg;
    logic [COORD_BITS-1:0]   lo_reg;
    logic [COORD_BITS-1:0]   m_reg;
    logic [COORD_BITS-1:0]   d_reg;
    coord_t                  ax_reg;
    logic                    neg_reg;
    logic                    flat_reg;

    logic signed [COORD_BITS:0] dx_w;
    logic signed [COORD_BITS:0] dy_w;
    logic signed [COORD_BITS:0] t_w;
    logic [COORD_BITS-1:0]      dx_mag;
    logic [COORD_BITS:0]        sum;
    logic [COORD_BITS:0]        shifted;
    logic [COORD_BITS:0]        diff;
    logic                       ge;
    logic                       last_step;
    logic signed [COORD_BITS:0] q_s;
    logic signed [COORD_BITS:0] x_w;

    // Edge deltas at start. The row never lies above a, and b never above a,
    // so dy and t are non-negative and fit the coordinate width unsigned.
    always_comb begin
        dx_w   = $signed({req.b_x[COORD_BITS-1], req.b_x})
               - $signed({req.a_x[COORD_BITS-1], req.a_x});
        dy_w   = $signed({req.b_y[COORD_BITS-1], req.b_y})
               - $signed({req.a_y[COORD_BITS-1], req.a_y});
        t_w    = $signed({req.y[COORD_BITS-1], req.y})
               - $signed({req.a_y[COORD_BITS-1], req.a_y});
        dx_mag = dx_w[COORD_BITS] ? COORD_BITS'(-dx_w) : dx_w[COORD_BITS-1:0];
    end

    // One multiply step: add the multiplicand when the low bit is set.
    // One divide step: shift in the next dividend bit and trial-subtract.
    always_comb begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, m_reg} : '0);
        shifted   = {hi_reg, lo_reg[COORD_BITS-1]};
        ge        = (shifted >= {1'b0, d_reg});
        diff      = shifted - {1'b0, d_reg};
        last_step = (cnt_reg == CNT_BITS'(COORD_BITS - 1));
    end

    // Control: multiply phase, then divide phase, each one bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                mul_reg  <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
                if (last_step) begin
                    if (mul_reg) begin
                        mul_reg <= 1'b0;
                    end else begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath shift registers: hi holds the partial product, then the
    // remainder; lo holds the multiplier bits, then the quotient bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            ax_reg   <= req.a_x;
            neg_reg  <= dx_w[COORD_BITS];
            flat_reg <= (req.a_y == req.b_y);
            m_reg    <= dx_mag;
            d_reg    <= dy_w[COORD_BITS-1:0];
            hi_reg   <= '0;
            lo_reg   <= t_w[COORD_BITS-1:0];
        end else if (busy_reg) begin
            if (mul_reg) begin
                hi_reg <= sum[COORD_BITS:1];
                lo_reg <= {sum[0], lo_reg[COORD_BITS-1:1]};
            end else begin
                hi_reg <= ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
                lo_reg <= {lo_reg[COORD_BITS-2:0], ge};
            end
        end
    end

    // The quotient is a magnitude truncated toward zero; apply the sign of dx.
    always_comb begin
        q_s   = neg_reg ? -$signed({1'b0, lo_reg}) : $signed({1'b0, lo_reg});
        x_w   = $signed({ax_reg[COORD_BITS-1], ax_reg}) + q_s;
        x_out = flat_reg ? ax_reg : x_w[COORD_BITS-1:0];
    end

    assign done = done_reg;

endmodule

// ----- src/triangle_span_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Triangle span rasterizer
// Loads a triangle, sorts its vertices by row and emits one horizontal span
// per span request while loaded, from the top row down to the bottom row.
//
//   Channel  Dir  Handshake           Contents
//   s_       in   s_tvalid/s_tready   tuser: op; tdata: ax,ay,bx,by,cx,cy,colour
//   m_       out  m_tvalid/m_tready   tdata: row,left,right,colour; tlast: last
//
// Both edge units run in parallel on each span request, each doing a
// bit-serial multiply and then a bit-serial divide, one bit per cycle.
// Reset is synchronous and active low, and clears all control state.
// A finished span waits in the output register; new requests are taken
// meanwhile, and a span that finishes while that register is full waits.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ax, ay, bx, by_coord, cx, cy, fill_colour (lowest bits first)
    input  logic [tsr_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row, span_left, span_right, span_colour, zero pad (lowest bits first)
    output logic [tsr_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                               m_tlast
);
    import tsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    coord_t                    top_x_reg, top_y_reg, mid_x_reg, mid_y_reg;
    coord_t                    low_x_reg, low_y_reg;
    logic [31:0]               colour_reg;
    coord_t                    row_reg;
    logic                      second_half_reg;
    logic                      pending_reg;
    logic                      m_tvalid_reg;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg;
    logic                      m_tlast_reg;

    logic       s_fire;
    logic       load_fire;
    logic       span_start;
    logic       emit_fire;
    coord_t     in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    coord_t     p0x, p0y, p1x, p1y, p2x, p2y, tx, ty;
    edge_req_t  long_req, short_req;
    logic       long_done, short_done;
    coord_t     long_x, short_x;
    coord_t     span_l, span_r;
    logic       last_next;

    // Request decode.
    always_comb begin
        s_fire     = s_tvalid && s_tready;
        load_fire  = s_fire && (s_tuser == OP_LOAD);
        span_start = s_fire && (s_tuser == OP_SPAN) && pending_reg;
        emit_fire  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
        in_ax = s_tdata[COORD_BITS-1:0];
        in_ay = s_tdata[2*COORD_BITS-1:COORD_BITS];
        in_bx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        in_by = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        in_cx = s_tdata[5*COORD_BITS-1:4*COORD_BITS];
        in_cy = s_tdata[6*COORD_BITS-1:5*COORD_BITS];
    end

    // Vertex sort by row: swap (a,b), then (a,c), then (b,c).
    always_comb begin
        tx = '0;
        ty = '0;
        p0x = in_ax; p0y = in_ay;
        p1x = in_bx; p1y = in_by;
        p2x = in_cx; p2y = in_cy;
        if (p1y < p0y) begin
            tx = p0x; ty = p0y; p0x = p1x; p0y = p1y; p1x = tx; p1y = ty;
        end
        if (p2y < p0y) begin
            tx = p0x; ty = p0y; p0x = p2x; p0y = p2y; p2x = tx; p2y = ty;
        end
        if (p2y < p1y) begin
            tx = p1x; ty = p1y; p1x = p2x; p1y = p2y; p2x = tx; p2y = ty;
        end
    end

    // Edge requests: the long edge runs top to bottom; the short edge is
    // top to middle in the upper half and middle to bottom in the lower half.
    always_comb begin
        long_req.a_x = top_x_reg;
        long_req.a_y = top_y_reg;
        long_req.b_x = low_x_reg;
        long_req.b_y = low_y_reg;
        long_req.y   = row_reg;
        short_req.a_x = second_half_reg ? mid_x_reg : top_x_reg;
        short_req.a_y = second_half_reg ? mid_y_reg : top_y_reg;
        short_req.b_x = second_half_reg ? low_x_reg : mid_x_reg;
        short_req.b_y = second_half_reg ? low_y_reg : mid_y_reg;
        short_req.y   = row_reg;
    end

    tsr_edge u_long (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (span_start),
        .req     (long_req),
        .done    (long_done),
        .x_out   (long_x)
    );

    tsr_edge u_short (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (span_start),
        .req     (short_req),
        .done    (short_done),
        .x_out   (short_x)
    );

    // Span ordering and end-of-triangle detection.
    always_comb begin
        span_l    = (short_x > long_x) ? long_x : short_x;
        span_r    = (short_x > long_x) ? short_x : long_x;
        last_next = second_half_reg && (row_reg >= low_y_reg);
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (span_start) state_next = ST_RUN;
            ST_RUN:  if (long_done)  state_next = ST_EMIT;
            ST_EMIT: if (emit_fire)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pending_reg     <= 1'b0;
            second_half_reg <= 1'b0;
            row_reg         <= '0;
            top_x_reg       <= '0;
            top_y_reg       <= '0;
            mid_x_reg       <= '0;
            mid_y_reg       <= '0;
            low_x_reg       <= '0;
            low_y_reg       <= '0;
            colour_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A taken result empties the output register unless a new span
            // refills it in the same cycle.
            if (m_tvalid_reg && m_tready && !emit_fire) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load_fire) begin
                top_x_reg       <= p0x;
                top_y_reg       <= p0y;
                mid_x_reg       <= p1x;
                mid_y_reg       <= p1y;
                low_x_reg       <= p2x;
                low_y_reg       <= p2y;
                colour_reg      <= s_tdata[6*COORD_BITS+31:6*COORD_BITS];
                row_reg         <= p0y;
                second_half_reg <= 1'b0;
                pending_reg     <= 1'b1;
            end
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
                if (!second_half_reg) begin
                    if (row_reg >= mid_y_reg) begin
                        second_half_reg <= 1'b1;
                        row_reg         <= mid_y_reg;
                    end else begin
                        row_reg <= row_reg + 1'b1;
                    end
                end else if (last_next) begin
                    pending_reg <= 1'b0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_tdata_reg <= OUT_TDATA_BITS'({colour_reg, span_r, span_l, row_reg});
            m_tlast_reg <= last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The edge units are started together and must finish together.
    a_edges_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        long_done == short_done)
        else $error("edge units out of step");

    // Work on a span only runs while a triangle is loaded.
    a_run_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> pending_reg)
        else $error("span in progress without a loaded triangle");

    // Emitting the final span retires the triangle.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && last_next) |=> (!pending_reg && m_tvalid && m_tlast))
        else $error("final span did not retire the triangle");

    // A span request is only accepted after the previous result was queued.
    a_emit_before_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && long_done) |=> (state_reg == ST_EMIT && !s_tready))
        else $error("finished span skipped the output stage");

endmodule

// ----- dv/triangle_span_rasterizer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle span rasterizer testbench
// Sends triangle loads and span requests over the input stream and checks
// every span on the output stream against a predictor of the scanline fill.
// The predictor keeps its own copy of the sorted vertices, the row counter
// and the half flag. A short directed part covers the coordinate extremes,
// flat and degenerate triangles and the no-op cases. The random part that
// follows is mostly complete triangles, with some cut short or padded.
// Both sides idle in random bursts, and once the receiver holds off long
// enough for the block to stall its input.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_test;
    import tsr_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 64;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int REPORT_LIMIT = 10;

    // One request on the input stream.
    typedef struct {
        logic        op;
        coord_t      ax;
        coord_t      ay;
        coord_t      bx;
        coord_t      by_coord;
        coord_t      cx;
        coord_t      cy;
        logic [31:0] colour;
    } raster_req_t;

    // One span on the output stream.
    typedef struct packed {
        coord_t      row;
        coord_t      span_left;
        coord_t      span_right;
        logic [31:0] colour;
        logic        last;
    } span_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // ax, ay, bx, by_coord, cx, cy, fill_colour (lowest bits first)
    logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
    // op
    logic                      s_tuser  = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // row, span_left, span_right, span_colour, zero pad (lowest bits first)
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;

    triangle_span_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    raster_req_t req_queue[$];
    span_t       span_queue[$];
    raster_req_t offered_req;
    logic        offer_live     = 1'b0;
    int          send_gap       = 0;
    int          stall_left     = 0;
    int          queued_total   = 0;
    int          accepted_total = 0;
    int          spans_checked  = 0;
    int          fail_count     = 0;
    logic        quiet_tail     = 1'b0;
    logic        hold_receiver  = 1'b0;
    span_t       got_span;
    span_t       want_span;

    // Predictor state: sorted vertices, colour and walk position.
    coord_t      top_x = '0, top_y = '0, mid_x = '0, mid_y = '0, low_x = '0, low_y = '0;
    logic [31:0] held_colour = '0;
    coord_t      cur_row     = '0;
    logic        lower_half  = 1'b0;
    logic        tri_loaded  = 1'b0;

    // X of the edge from (x0, y0) to (x1, y1) at row y, truncating toward zero.
    function automatic int edge_x_at(int x0, int y0, int x1, int y1, int y);
        if (y0 == y1)
            return x0;
        return x0 + ((x1 - x0) * (y - y0)) / (y1 - y0);
    endfunction

    // Apply one accepted request to the predictor and queue the span it yields.
    task automatic rasterize_request(input raster_req_t r);
        coord_t px[3];
        coord_t py[3];
        coord_t t;
        coord_t row;
        int     xl;
        int     xr;
        int     xt;
        span_t  s;
        if (r.op == OP_LOAD) begin
            px[0] = r.ax; py[0] = r.ay;
            px[1] = r.bx; py[1] = r.by_coord;
            px[2] = r.cx; py[2] = r.cy;
            // Three conditional swaps put the vertices in row order.
            if (py[1] < py[0]) begin
                t = px[0]; px[0] = px[1]; px[1] = t;
                t = py[0]; py[0] = py[1]; py[1] = t;
            end
            if (py[2] < py[0]) begin
                t = px[0]; px[0] = px[2]; px[2] = t;
                t = py[0]; py[0] = py[2]; py[2] = t;
            end
            if (py[2] < py[1]) begin
                t = px[1]; px[1] = px[2]; px[2] = t;
                t = py[1]; py[1] = py[2]; py[2] = t;
            end
            top_x = px[0]; top_y = py[0];
            mid_x = px[1]; mid_y = py[1];
            low_x = px[2]; low_y = py[2];
            held_colour = r.colour;
            cur_row = py[0];
            lower_half = 1'b0;
            tri_loaded = 1'b1;
        end else if (tri_loaded) begin
            row = cur_row;
            s.last = 1'b0;
            xr = edge_x_at(top_x, top_y, low_x, low_y, row);
            if (!lower_half) begin
                xl = edge_x_at(top_x, top_y, mid_x, mid_y, row);
                if (row >= mid_y) begin
                    // The middle row starts the lower half again.
                    lower_half = 1'b1;
                    cur_row = mid_y;
                end else begin
                    cur_row = coord_t'(row + 1);
                end
            end else begin
                xl = edge_x_at(mid_x, mid_y, low_x, low_y, row);
                if (row >= low_y) begin
                    s.last = 1'b1;
                    tri_loaded = 1'b0;
                end else begin
                    cur_row = coord_t'(row + 1);
                end
            end
            if (xl > xr) begin
                xt = xl; xl = xr; xr = xt;
            end
            s.row = row;
            s.span_left = coord_t'(xl);
            s.span_right = coord_t'(xr);
            s.colour = held_colour;
            span_queue.push_back(s);
        end
    endtask

    task automatic queue_request(input logic op, input coord_t ax, input coord_t ay,
                                 input coord_t bx, input coord_t by_coord,
                                 input coord_t cx, input coord_t cy,
                                 input logic [31:0] colour);
        raster_req_t r;
        r.op = op;
        r.ax = ax; r.ay = ay;
        r.bx = bx; r.by_coord = by_coord;
        r.cx = cx; r.cy = cy;
        r.colour = colour;
        req_queue.push_back(r);
        queued_total++;
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // Span requests carry random payload, which the block must ignore.
    task automatic queue_spans(input int count);
        repeat (count)
            queue_request(OP_SPAN, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), $urandom);
    endtask

    // Driver: offers queued requests and feeds accepted ones to the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rasterize_request(offered_req);
                accepted_total++;
                offer_live = 1'b0;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 16);
            end
            if (!offer_live) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_queue.size() > 0) begin
                    offered_req = req_queue.pop_front();
                    offer_live = 1'b1;
                end
            end
            quiet_tail <= (req_queue.size() < TAIL_ITEMS);
            s_tvalid <= offer_live;
            s_tuser  <= offered_req.op;
            s_tdata  <= IN_TDATA_BITS'({offered_req.colour, offered_req.cy, offered_req.cx,
                                        offered_req.by_coord, offered_req.bx,
                                        offered_req.ay, offered_req.ax});
        end
    end

    // Monitor: checks each span against the oldest prediction and drives ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_span.row        = m_tdata[0 +: COORD_BITS];
                got_span.span_left  = m_tdata[COORD_BITS +: COORD_BITS];
                got_span.span_right = m_tdata[2*COORD_BITS +: COORD_BITS];
                got_span.colour     = m_tdata[3*COORD_BITS +: 32];
                got_span.last       = m_tlast;
                spans_checked++;
                if (span_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected span: row %0d left %0d right %0d colour %h last %0b",
                                 got_span.row, got_span.span_left, got_span.span_right,
                                 got_span.colour, got_span.last);
                end else begin
                    want_span = span_queue.pop_front();
                    if (got_span != want_span) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("span mismatch: want row %0d left %0d right %0d colour %h last %0b",
                                     want_span.row, want_span.span_left, want_span.span_right,
                                     want_span.colour, want_span.last);
                            $display("                got row %0d left %0d right %0d colour %h last %0b",
                                     got_span.row, got_span.span_left, got_span.span_right,
                                     got_span.colour, got_span.last);
                        end
                    end
                end
            end
            if (hold_receiver) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the output register fills and the input stalls.
    initial begin
        while (spans_checked < 150)
            @(posedge aclk);
        hold_receiver <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge aclk);
        hold_receiver <= 1'b0;
    end

    // Stimulus, reset and end of run.
    initial begin
        int     pick;
        int     h;
        int     top;
        int     k;
        coord_t ys[3];
        coord_t ty;

        // A span request before any triangle is loaded gives nothing.
        queue_spans(1);
        // Degenerate triangle on the lowest row: that row twice, then done.
        queue_request(OP_LOAD, -2048, -2048, 2047, -2048, 0, -2048, 32'h0000_0000);
        queue_spans(2);
        // Vertices in reverse row order near the bottom edge: all three swaps.
        queue_request(OP_LOAD, 2047, 2047, -2048, 2046, 0, 2045, 32'hFFFF_FFFF);
        queue_spans(4);
        // Flat top.
        queue_request(OP_LOAD, -2048, 100, 2047, 100, 5, 101, 32'hA5A5_5A5A);
        queue_spans(3);
        // Flat bottom.
        queue_request(OP_LOAD, -7, -300, 2047, -298, -2048, -298, 32'h5A5A_A5A5);
        queue_spans(4);
        // Full-height triangle, cut short by the next load.
        queue_request(OP_LOAD, -2048, -2048, 2047, 2047, 0, 0, 32'h1234_5678);
        queue_spans(3);
        // Single-row triangle, then one request too many.
        queue_request(OP_LOAD, 10, 5, 12, 5, 11, 5, 32'h8000_0001);
        queue_spans(3);

        // Random part: mostly complete triangles of small height.
        while (queued_total < RANDOM_ITEMS + 26) begin
            pick = $urandom_range(0, 99);
            h = ($urandom_range(0, 39) == 0) ? $urandom_range(16, 200) : $urandom_range(0, 10);
            top = $urandom_range(0, 4095 - h) - 2048;
            ys[0] = coord_t'(top);
            ys[1] = coord_t'(top + h);
            ys[2] = coord_t'(top + $urandom_range(0, h));
            k = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1) begin
                ty = ys[1]; ys[1] = ys[2]; ys[2] = ty;
            end
            if (pick < 92)
                queue_request(OP_LOAD, rand_coord(), ys[k], rand_coord(), ys[(k + 1) % 3],
                              rand_coord(), ys[(k + 2) % 3], $urandom);
            if (pick < 80) begin
                queue_spans(h + 2 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0));
            end else if (pick < 92) begin
                queue_spans($urandom_range(0, h + 1));
            end else begin
                // Noise: requests of either kind with arbitrary fields.
                repeat ($urandom_range(1, 4))
                    queue_request(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  $urandom);
            end
        end

        repeat (9)
            @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_total < queued_total)
            @(posedge aclk);
        while (span_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        fail_count += span_queue.size();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tsr_pkg.sv
src/tsr_edge.sv
src/triangle_span_rasterizer.sv
dv/triangle_span_rasterizer_test.sv
